FILE: design/bfs_pkg.sv
// Shared types and codes for the breadth-first search engine.
// No dependencies; imported by bfs_graph_mem and breadth_first_search.
`default_nettype none

package bfs_pkg;

    // default sizes
    localparam int DEF_MAX_NODES = 64;
    localparam int DEF_MAX_EDGES = 256;

    // fixed field widths
    localparam int VTX_W   = 6;
    localparam int SLOT_W  = 8;
    localparam int DEG_W   = 9;
    localparam int SUM_W   = 10;   // first slot plus run offset
    localparam int LIM_W   = 13;   // holds the largest edge table size
    localparam int CNT_W   = 7;    // node_count register

    // input word opcodes
    localparam logic [1:0] OP_NODE   = 2'd0;
    localparam logic [1:0] OP_EDGE   = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;

    // result status codes
    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_RANGE  = 2'd1;
    localparam logic [1:0] STATUS_MASKED = 2'd2;

    // register indexes
    localparam logic REG_NODE_COUNT = 1'b0;
    localparam logic REG_USE_MASK   = 1'b1;

    typedef struct packed {
        logic               enabled;
        logic [DEG_W-1:0]   degree;
        logic [SLOT_W-1:0]  first;
    } node_entry_t;

    typedef struct packed {
        logic               enabled;
        logic [VTX_W-1:0]   dest;
    } edge_entry_t;

    typedef struct packed {
        logic [VTX_W-1:0]   pred;
        logic [VTX_W-1:0]   hops;
        logic [VTX_W-1:0]   vertex;
    } queue_entry_t;

endpackage

`default_nettype wire

FILE: design/breadth_first_search.sv
// Breadth-first search engine: top level with walk sequencer, queue and output register.
// Uses bfs_pkg and bfs_graph_mem.
// Node and edge loads are written into their tables as the word is taken. A search
// runs a sequencer around one slot adder and compare unit and one read port per
// table: it checks the source, clears the visited marks of the node count's vertices,
// then per dequeued vertex reads its queue and node entries and walks its edge slots,
// skipping out-of-table slots in place and checking each target for range and edge
// enable, then for its visited mark and node enable. Once the queue is drained it
// presents the results, holding while the output side stalls. A failed source check
// presents a single result. The block takes no new word until the last result of a
// search is in the output register; that register lets the next word in while it
// waits to be taken.
`default_nettype none

module breadth_first_search
    import bfs_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES,
    parameter int MAX_EDGES = DEF_MAX_EDGES
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input words
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // node_index[5:0], first_edge[13:6], edge_count[22:14], node_allowed[23],
    // edge_index[31:24], edge_target[37:32], edge_allowed[38], source[44:39]
    input  wire logic [47:0] s_tdata,
    // op[1:0]
    input  wire logic [1:0]  s_tuser,
    // result words
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // status[1:0], vertex[7:2], distance[13:8], predecessor[19:14]
    output logic [23:0]      m_tdata,
    output logic             m_tlast,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int EDGE_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int PTR_W  = NODE_W + 1;
    localparam logic [CNT_W-1:0] MAX_NODES_C = CNT_W'(MAX_NODES);
    localparam logic [LIM_W-1:0] MAX_EDGES_C = LIM_W'(MAX_EDGES);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CHK   = 4'd1;
    localparam logic [3:0] ST_DEQ   = 4'd2;
    localparam logic [3:0] ST_LOADU = 4'd3;
    localparam logic [3:0] ST_EINIT = 4'd4;
    localparam logic [3:0] ST_SCAN  = 4'd5;
    localparam logic [3:0] ST_ECHK  = 4'd6;
    localparam logic [3:0] ST_NCHK  = 4'd7;
    localparam logic [3:0] ST_ORD   = 4'd8;
    localparam logic [3:0] ST_OWAIT = 4'd9;
    localparam logic [3:0] ST_ERR   = 4'd10;
    localparam logic [3:0] ST_CLR   = 4'd11;

    // input fields
    logic [1:0]        in_op;
    logic [VTX_W-1:0]  in_node_index;
    logic [SLOT_W-1:0] in_first_edge;
    logic [DEG_W-1:0]  in_edge_count;
    logic              in_node_allowed;
    logic [7:0]        in_edge_index;
    logic [VTX_W-1:0]  in_edge_target;
    logic              in_edge_allowed;
    logic [VTX_W-1:0]  in_source;

    assign in_op           = s_tuser;
    assign in_node_index   = s_tdata[5:0];
    assign in_first_edge   = s_tdata[13:6];
    assign in_edge_count   = s_tdata[22:14];
    assign in_node_allowed = s_tdata[23];
    assign in_edge_index   = s_tdata[31:24];
    assign in_edge_target  = s_tdata[37:32];
    assign in_edge_allowed = s_tdata[38];
    assign in_source       = s_tdata[44:39];

    // registers
    logic [3:0]           state_reg, state_next;
    logic [CNT_W-1:0]     node_count_reg;
    logic                 use_mask_reg;
    logic [VTX_W-1:0]     src_reg, src_next;
    logic [PTR_W-1:0]     head_reg, head_next;
    logic [PTR_W-1:0]     tail_reg, tail_next;
    logic [PTR_W-1:0]     idx_reg, idx_next;
    logic [VTX_W-1:0]     u_reg, u_next;
    logic [VTX_W-1:0]     du_reg, du_next;
    logic [SLOT_W-1:0]    base_reg, base_next;
    logic [DEG_W-1:0]     cnt_reg, cnt_next;
    logic [DEG_W-1:0]     k_reg, k_next;
    logic [VTX_W-1:0]     v_reg, v_next;
    logic [1:0]           err_reg, err_next;
    logic                 m_valid_reg, m_valid_next;
    logic [23:0]          m_data_reg, m_data_next;
    logic                 m_last_reg, m_last_next;

    // tables
    logic          accept;
    logic          node_we, edge_we;
    logic [LIM_W-1:0] edge_index_ext;
    node_entry_t   node_wdata, node_rd;
    edge_entry_t   edge_wdata, edge_rd;
    logic [NODE_W-1:0] node_raddr;
    logic [EDGE_W-1:0] edge_raddr;

    // discovery queue
    queue_entry_t  queue_mem [MAX_NODES];
    queue_entry_t  q_rd_reg;
    queue_entry_t  q_wdata;
    logic          q_we;
    logic [NODE_W-1:0] q_waddr, q_raddr;

    // visited marks
    logic          visit_mem [MAX_NODES];
    logic          visit_rd_reg;
    logic          visit_we;
    logic          visit_wdata;
    logic [NODE_W-1:0] visit_waddr, visit_raddr;

    // shared slot unit
    logic [SUM_W-1:0] slot_sum;
    logic [LIM_W-1:0] slot_ext;
    logic             slot_in_table;
    logic [CNT_W-1:0] n_eff;
    logic             out_free;
    logic             cfg_we;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_tready;
    assign n_eff    = (node_count_reg > MAX_NODES_C) ? MAX_NODES_C : node_count_reg;

    assign slot_sum      = {2'b00, base_reg} + {1'b0, k_reg};
    assign slot_ext      = {{(LIM_W-SUM_W){1'b0}}, slot_sum};
    assign slot_in_table = (slot_ext < MAX_EDGES_C);

    assign edge_index_ext = {{(LIM_W-8){1'b0}}, in_edge_index};
    assign node_we = accept && (in_op == OP_NODE)
                     && ({1'b0, in_node_index} < MAX_NODES_C);
    assign edge_we = accept && (in_op == OP_EDGE) && (edge_index_ext < MAX_EDGES_C);
    assign node_wdata = '{enabled: in_node_allowed, degree: in_edge_count,
                          first: in_first_edge};
    assign edge_wdata = '{enabled: in_edge_allowed, dest: in_edge_target};

    always_comb begin
        case (state_reg)
            ST_LOADU: node_raddr = q_rd_reg.vertex[NODE_W-1:0];
            ST_ECHK:  node_raddr = edge_rd.dest[NODE_W-1:0];
            default:  node_raddr = in_source[NODE_W-1:0];
        endcase
    end
    assign edge_raddr = slot_ext[EDGE_W-1:0];

    bfs_graph_mem #(
        .MAX_NODES(MAX_NODES),
        .MAX_EDGES(MAX_EDGES)
    ) u_graph (
        .aclk      (aclk),
        .node_we   (node_we),
        .node_waddr(in_node_index[NODE_W-1:0]),
        .node_wdata(node_wdata),
        .node_raddr(node_raddr),
        .node_rdata(node_rd),
        .edge_we   (edge_we),
        .edge_waddr(edge_index_ext[EDGE_W-1:0]),
        .edge_wdata(edge_wdata),
        .edge_raddr(edge_raddr),
        .edge_rdata(edge_rd)
    );

    assign q_raddr = (state_reg == ST_DEQ) ? head_reg[NODE_W-1:0] : idx_reg[NODE_W-1:0];

    always_ff @(posedge aclk) begin
        if (q_we) begin
            queue_mem[q_waddr] <= q_wdata;
        end
        q_rd_reg <= queue_mem[q_raddr];
    end

    // mark of the edge target, ready in the cycle after the edge entry
    assign visit_raddr = edge_rd.dest[NODE_W-1:0];

    always_ff @(posedge aclk) begin
        if (visit_we) begin
            visit_mem[visit_waddr] <= visit_wdata;
        end
        visit_rd_reg <= visit_mem[visit_raddr];
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        src_next     = src_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        idx_next     = idx_reg;
        u_next       = u_reg;
        du_next      = du_reg;
        base_next    = base_reg;
        cnt_next     = cnt_reg;
        k_next       = k_reg;
        v_next       = v_reg;
        err_next     = err_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        q_we         = 1'b0;
        q_waddr      = tail_reg[NODE_W-1:0];
        q_wdata      = '{pred: u_reg, hops: du_reg + 6'd1, vertex: edge_rd.dest};
        visit_we     = 1'b0;
        visit_waddr  = v_reg[NODE_W-1:0];
        visit_wdata  = 1'b1;

        case (state_reg)
            ST_IDLE: begin
                if (accept && (in_op == OP_SEARCH)) begin
                    src_next = in_source;
                    if ({1'b0, in_source} >= n_eff) begin
                        err_next   = STATUS_RANGE;
                        state_next = ST_ERR;
                    end else begin
                        state_next = ST_CHK;
                    end
                end
            end
            ST_CHK: begin
                if (use_mask_reg && !node_rd.enabled) begin
                    err_next   = STATUS_MASKED;
                    state_next = ST_ERR;
                end else begin
                    q_we       = 1'b1;
                    q_waddr    = '0;
                    q_wdata    = '{pred: src_reg, hops: '0, vertex: src_reg};
                    head_next  = '0;
                    tail_next  = PTR_W'(1);
                    idx_next   = '0;
                    state_next = ST_CLR;
                end
            end
            ST_CLR: begin
                // clear the marks of the live vertices, setting only the source
                visit_we    = 1'b1;
                visit_waddr = idx_reg[NODE_W-1:0];
                visit_wdata = (idx_reg[NODE_W-1:0] == src_reg[NODE_W-1:0]);
                if (CNT_W'(idx_reg) + CNT_W'(1) == n_eff) begin
                    state_next = ST_DEQ;
                end else begin
                    idx_next = idx_reg + PTR_W'(1);
                end
            end
            ST_DEQ: begin
                if (head_reg == tail_reg) begin
                    idx_next   = '0;
                    state_next = ST_ORD;
                end else begin
                    head_next  = head_reg + PTR_W'(1);
                    state_next = ST_LOADU;
                end
            end
            ST_LOADU: begin
                u_next     = q_rd_reg.vertex;
                du_next    = q_rd_reg.hops;
                state_next = ST_EINIT;
            end
            ST_EINIT: begin
                base_next  = node_rd.first;
                cnt_next   = node_rd.degree;
                k_next     = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (k_reg == cnt_reg) begin
                    state_next = ST_DEQ;
                end else begin
                    k_next = k_reg + DEG_W'(1);
                    // slots past the table end are skipped in place
                    if (slot_in_table) begin
                        state_next = ST_ECHK;
                    end
                end
            end
            ST_ECHK: begin
                state_next = ST_SCAN;
                v_next     = edge_rd.dest;
                if (({1'b0, edge_rd.dest} < n_eff)
                    && !(use_mask_reg && !edge_rd.enabled)) begin
                    state_next = ST_NCHK;
                end
            end
            ST_NCHK: begin
                state_next = ST_SCAN;
                q_wdata    = '{pred: u_reg, hops: du_reg + 6'd1, vertex: v_reg};
                if (!visit_rd_reg && !(use_mask_reg && !node_rd.enabled)) begin
                    visit_we  = 1'b1;
                    q_we      = 1'b1;
                    tail_next = tail_reg + PTR_W'(1);
                end
            end
            ST_ORD: begin
                state_next = ST_OWAIT;
            end
            ST_OWAIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {4'b0000, q_rd_reg.pred, q_rd_reg.hops,
                                    q_rd_reg.vertex, STATUS_OK};
                    m_last_next  = (idx_reg + PTR_W'(1) == tail_reg);
                    idx_next     = idx_reg + PTR_W'(1);
                    state_next   = (idx_reg + PTR_W'(1) == tail_reg) ? ST_IDLE : ST_ORD;
                end
            end
            ST_ERR: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {22'd0, err_reg};
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            head_reg    <= '0;
            tail_reg    <= '0;
            idx_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            idx_reg     <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        src_reg    <= src_next;
        u_reg      <= u_next;
        du_reg     <= du_next;
        base_reg   <= base_next;
        cnt_reg    <= cnt_next;
        k_reg      <= k_next;
        v_reg      <= v_next;
        err_reg    <= err_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    // configuration registers
    assign cfg_we = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= CNT_W'(1);
            use_mask_reg   <= 1'b0;
        end else if (cfg_we) begin
            case (paddr[2])
                REG_NODE_COUNT: node_count_reg <= pwdata[CNT_W-1:0];
                REG_USE_MASK:   use_mask_reg   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_NODE_COUNT: prdata = {{(32-CNT_W){1'b0}}, node_count_reg};
            REG_USE_MASK:   prdata = {31'd0, use_mask_reg};
            default:        prdata = '0;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // the queue never holds more vertices than the graph has
    a_tail_within_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLR || state_reg == ST_DEQ || state_reg == ST_LOADU
         || state_reg == ST_EINIT || state_reg == ST_SCAN || state_reg == ST_ECHK
         || state_reg == ST_NCHK)
        |-> (int'(tail_reg) <= int'(n_eff)))
        else $error("queue fill beyond vertex count");

    a_head_behind_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE && state_reg != ST_CHK && state_reg != ST_ERR)
        |-> (head_reg <= tail_reg && tail_reg <= PTR_W'(MAX_NODES)))
        else $error("queue pointers out of order");

    a_drain_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ORD || state_reg == ST_OWAIT) |-> (idx_reg < tail_reg))
        else $error("result index past queue fill");

    a_last_ends_search: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OWAIT && out_free && m_last_next) |=> (state_reg == ST_IDLE))
        else $error("final result did not return sequencer to idle");

endmodule

`default_nettype wire

FILE: design/bfs_graph_mem.sv
// Node and edge tables of the graph in compressed adjacency form.
// One write and one registered read per table each cycle; uses bfs_pkg.
`default_nettype none

module bfs_graph_mem
    import bfs_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES,
    parameter int MAX_EDGES = DEF_MAX_EDGES,
    localparam int NODE_W = $clog2(MAX_NODES),
    localparam int EDGE_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1
) (
    input  wire logic               aclk,
    input  wire logic               node_we,
    input  wire logic [NODE_W-1:0]  node_waddr,
    input  wire node_entry_t        node_wdata,
    input  wire logic [NODE_W-1:0]  node_raddr,
    output node_entry_t             node_rdata,
    input  wire logic               edge_we,
    input  wire logic [EDGE_W-1:0]  edge_waddr,
    input  wire edge_entry_t        edge_wdata,
    input  wire logic [EDGE_W-1:0]  edge_raddr,
    output edge_entry_t             edge_rdata
);

    node_entry_t node_mem [MAX_NODES];
    edge_entry_t edge_mem [MAX_EDGES];
    node_entry_t node_rd_reg;
    edge_entry_t edge_rd_reg;

    always_ff @(posedge aclk) begin
        if (node_we) begin
            node_mem[node_waddr] <= node_wdata;
        end
        node_rd_reg <= node_mem[node_raddr];
    end

    always_ff @(posedge aclk) begin
        if (edge_we) begin
            edge_mem[edge_waddr] <= edge_wdata;
        end
        edge_rd_reg <= edge_mem[edge_raddr];
    end

    assign node_rdata = node_rd_reg;
    assign edge_rdata = edge_rd_reg;

endmodule

`default_nettype wire

FILE: tb/breadth_first_search_tb.sv
// Self-checking testbench for breadth_first_search: graph loads, searches and
// register writes over the stream and APB ports, checked by an internal predictor.
// Depends on bfs_pkg and the breadth_first_search RTL only.
`default_nettype none

module breadth_first_search_tb
    import bfs_pkg::*;
();

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         QUIET_LIMIT = 200000;
    localparam int         SETTLE      = 8;
    localparam int         PHASE_WORDS = 36;

    // input word as carried on s_tdata, lowest field last
    typedef struct packed {
        logic [2:0] pad;
        logic [5:0] source;
        logic       edge_allowed;
        logic [5:0] edge_target;
        logic [7:0] edge_index;
        logic       node_allowed;
        logic [8:0] edge_count;
        logic [7:0] first_edge;
        logic [5:0] node_index;
    } in_word_t;

    // result word as carried on m_tdata
    typedef struct packed {
        logic [3:0] pad;
        logic [5:0] predecessor;
        logic [5:0] distance;
        logic [5:0] vertex;
        logic [1:0] status;
    } res_word_t;

    typedef struct packed {
        logic      last;
        res_word_t w;
    } visit_t;

    class bfs_scoreboard;
        logic [6:0] count_reg;
        logic       mask_reg;
        logic [7:0] first_slot[64];
        logic [8:0] degree[64];
        logic       node_on[64];
        logic [5:0] dest[256];
        logic       edge_on[256];
        visit_t     visits_q[$];
        int errors;
        int checked;
        int searches;
        int range_misses;
        int filtered;

        function new();
            count_reg = 7'd1;
            mask_reg  = 1'b0;
        endfunction

        function void report(string msg);
            $display("ERROR at %0t: %s", $realtime, msg);
            errors++;
        endfunction

        function void set_reg(logic idx, logic [31:0] value);
            if (idx == REG_NODE_COUNT) count_reg = value[6:0];
            else mask_reg = value[0];
        endfunction

        function void push_visit(logic [1:0] st, logic [5:0] v, logic [5:0] d,
                                 logic [5:0] p, logic lst);
            visit_t e;
            e.w = '0;
            e.w.status = st;
            e.w.vertex = v;
            e.w.distance = d;
            e.w.predecessor = p;
            e.last = lst;
            visits_q.insert(visits_q.size(), e);
        endfunction

        // FIFO walk from src; results are queued in discovery order
        function void walk(logic [5:0] src);
            int lim, head, tail, k, u, v, slot;
            bit seen[64];
            logic [5:0] order[64];
            logic [5:0] hops[64];
            logic [5:0] from[64];
            searches++;
            lim = (count_reg > 64) ? 64 : count_reg;
            if (src >= lim) begin
                range_misses++;
                push_visit(STATUS_RANGE, 6'd0, 6'd0, 6'd0, 1'b1);
                return;
            end
            if (mask_reg && !node_on[src]) begin
                filtered++;
                push_visit(STATUS_MASKED, 6'd0, 6'd0, 6'd0, 1'b1);
                return;
            end
            seen = '{default: 1'b0};
            head = 0;
            tail = 1;
            seen[src] = 1'b1;
            hops[src] = '0;
            from[src] = src;
            order[0] = src;
            while (head < tail) begin
                u = order[head];
                head++;
                for (k = 0; k < degree[u]; k++) begin
                    slot = first_slot[u] + k;
                    if (slot >= 256) continue;
                    v = dest[slot];
                    if (v >= lim) continue;
                    if (mask_reg && (!edge_on[slot] || !node_on[v])) continue;
                    if (seen[v] || tail >= 64) continue;
                    seen[v] = 1'b1;
                    hops[v] = hops[u] + 6'd1;
                    from[v] = 6'(u);
                    order[tail] = 6'(v);
                    tail++;
                end
            end
            for (k = 0; k < tail; k++)
                push_visit(STATUS_OK, order[k], hops[order[k]], from[order[k]],
                           k == tail - 1);
        endfunction

        function void note_word(logic [1:0] op, in_word_t w);
            case (op)
                OP_NODE: begin
                    first_slot[w.node_index] = w.first_edge;
                    degree[w.node_index]     = w.edge_count;
                    node_on[w.node_index]    = w.node_allowed;
                end
                OP_EDGE: begin
                    dest[w.edge_index]    = w.edge_target;
                    edge_on[w.edge_index] = w.edge_allowed;
                end
                OP_SEARCH: walk(w.source);
                default: ;
            endcase
        endfunction

        function void check_result(res_word_t got, logic got_last);
            visit_t e;
            if (visits_q.size() == 0) begin
                report($sformatf("result word with nothing outstanding: vertex %0d status %0d",
                                 got.vertex, got.status));
                return;
            end
            e = visits_q.pop_front();
            checked++;
            if (got.status !== e.w.status)
                report($sformatf("word %0d status: got %0d, want %0d",
                                 checked, got.status, e.w.status));
            if (got.vertex !== e.w.vertex)
                report($sformatf("word %0d vertex: got %0d, want %0d",
                                 checked, got.vertex, e.w.vertex));
            if (got.distance !== e.w.distance)
                report($sformatf("word %0d distance: got %0d, want %0d",
                                 checked, got.distance, e.w.distance));
            if (got.predecessor !== e.w.predecessor)
                report($sformatf("word %0d predecessor: got %0d, want %0d",
                                 checked, got.predecessor, e.w.predecessor));
            if (got_last !== e.last)
                report($sformatf("word %0d last: got %0d, want %0d",
                                 checked, got_last, e.last));
        endfunction

        function int pending();
            return visits_q.size();
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    bfs_scoreboard sb;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_request = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int words_sent = 0;
    int reg_writes = 0;

    // what the stimulus has loaded so far, so that no search reads a blank entry
    bit         gn_written[64];
    logic [7:0] gn_first[64];
    logic [8:0] gn_deg[64];
    bit         ge_written[256];
    int         cur_limit = 1;

    breadth_first_search uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // result side: random stalls, or a counted hold-off when one is requested
    always @(posedge aclk) begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
            if (s_tvalid && s_tready) sb.note_word(s_tuser, s_tdata);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            sb.report("no handshake for too long, giving up");
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function in_word_t random_word();
        logic [47:0] raw;
        in_word_t w;
        raw[31:0]  = $urandom;
        raw[47:32] = 16'($urandom_range(65535));
        w = raw;
        w.pad = '0;
        return w;
    endfunction

    function logic [8:0] pick_degree();
        int r;
        r = $urandom_range(99);
        if (r < 80) return 9'($urandom_range(4));
        if (r < 94) return 9'($urandom_range(5, 20));
        if (r < 97) return 9'd256;
        return 9'($urandom_range(21, 255));
    endfunction

    // mostly inside the current graph, now and then anywhere
    function logic [5:0] pick_vertex();
        if (cur_limit > 0 && $urandom_range(99) < 85) return 6'($urandom_range(cur_limit - 1));
        return 6'($urandom_range(63));
    endfunction

    task send_word(input logic [1:0] op, input in_word_t w);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= w;
        do @(posedge aclk); while (!s_tready);
        if (op != OP_UNUSED) words_sent++;
    endtask

    task load_node(input logic [5:0] idx, input logic [7:0] first, input logic [8:0] cnt,
                   input logic allow);
        in_word_t w;
        w = random_word();
        w.node_index   = idx;
        w.first_edge   = first;
        w.edge_count   = cnt;
        w.node_allowed = allow;
        gn_written[idx] = 1'b1;
        gn_first[idx]   = first;
        gn_deg[idx]     = cnt;
        send_word(OP_NODE, w);
    endtask

    task load_edge(input logic [7:0] idx, input logic [5:0] tgt, input logic allow);
        in_word_t w;
        w = random_word();
        w.edge_index   = idx;
        w.edge_target  = tgt;
        w.edge_allowed = allow;
        ge_written[idx] = 1'b1;
        send_word(OP_EDGE, w);
    endtask

    // load every entry a search over the current graph could read
    task fill_graph();
        int i, k, slot;
        for (i = 0; i < cur_limit; i++)
            if (!gn_written[i])
                load_node(6'(i), 8'($urandom_range(255)), 9'($urandom_range(3)),
                          $urandom_range(99) < 80);
        for (i = 0; i < cur_limit; i++)
            for (k = 0; k < gn_deg[i]; k++) begin
                slot = gn_first[i] + k;
                if (slot < 256 && !ge_written[slot])
                    load_edge(8'(slot), pick_vertex(), $urandom_range(99) < 80);
            end
    endtask

    task issue_search(input logic [5:0] src);
        in_word_t w;
        fill_graph();
        w = random_word();
        w.source = src;
        send_word(OP_SEARCH, w);
    endtask

    // stop offering words until every expected result is back, then let loads settle
    task wait_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task apb_write(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, value);
        reg_writes++;
        if (idx == REG_NODE_COUNT) cur_limit = (value[6:0] > 64) ? 64 : value[6:0];
        @(posedge aclk);
    endtask

    task apb_check(input logic idx, input logic [31:0] want);
        logic [31:0] keep;
        keep = (idx == REG_NODE_COUNT) ? 32'h7f : 32'h1;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if ((prdata & keep) !== (want & keep))
            sb.report($sformatf("register %0d reads %0h, want %0h", idx, prdata & keep,
                                want & keep));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        int ph, r, start, nc;
        logic [8:0] deg;
        sb = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset registers, single-vertex graph, range check, unused opcode
        apb_check(REG_NODE_COUNT, 1);
        apb_check(REG_USE_MASK, 0);
        load_node(0, 8'd0, 9'd0, 1'b1);
        issue_search(0);
        issue_search(63);
        send_word(OP_UNUSED, random_word());

        // small graph: disabled edge, disabled node, target out of range, and a run
        // that spills past the end of the edge table
        wait_results();
        apb_write(REG_NODE_COUNT, 4);
        apb_write(REG_USE_MASK, 1);
        load_node(1, 8'd253, 9'd256, 1'b1);
        load_node(2, 8'd2, 9'd1, 1'b0);
        load_node(3, 8'd3, 9'd1, 1'b1);
        load_node(0, 8'd0, 9'd2, 1'b1);
        load_edge(0, 1, 1'b1);
        load_edge(1, 2, 1'b0);
        load_edge(2, 3, 1'b1);
        load_edge(3, 63, 1'b1);
        load_edge(253, 3, 1'b1);
        load_edge(254, 2, 1'b1);
        load_edge(255, 45, 1'b1);
        issue_search(0);
        issue_search(2);
        wait_results();
        apb_write(REG_USE_MASK, 0);
        issue_search(0);
        issue_search(3);
        wait_results();
        apb_write(REG_NODE_COUNT, 0);
        issue_search(0);

        // random phases, each with its own settings and idling profile
        for (ph = 0; ph < 8; ph++) begin
            wait_results();
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 70; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 70; end
                default: begin send_idle_pct = 24; stall_pct = 24; end
            endcase
            nc = (ph == 5) ? 64 : (ph == 7) ? 127 : $urandom_range(2, 16);
            apb_write(REG_NODE_COUNT, nc);
            apb_write(REG_USE_MASK, $urandom_range(1));
            if (ph % 2) begin
                apb_check(REG_NODE_COUNT, nc);
                apb_check(REG_USE_MASK, sb.mask_reg);
            end
            // hold the result side off while words keep coming, so the block backs up
            if (ph == 0) hold_request = 400;
            start = words_sent;
            while (words_sent - start < PHASE_WORDS) begin
                r = $urandom_range(99);
                if (r < 15) begin
                    deg = pick_degree();
                    load_node(($urandom_range(99) < 75) ? pick_vertex()
                                                        : 6'($urandom_range(63)),
                              (deg > 20) ? 8'($urandom_range(180, 255))
                                         : 8'($urandom_range(255)),
                              deg, $urandom_range(99) < 80);
                end else if (r < 35) begin
                    load_edge(8'($urandom_range(255)), pick_vertex(),
                              $urandom_range(99) < 80);
                end else if (r < 37) begin
                    wait_results();
                end else begin
                    issue_search(pick_vertex());
                end
            end
        end

        wait_results();
        if (sb.pending() != 0)
            sb.report($sformatf("%0d expected result words never arrived", sb.pending()));
        $display("Covered %0d input words with %0d searches (%0d out of range, %0d filtered)",
                 words_sent, sb.searches, sb.range_misses, sb.filtered);
        $display("and %0d result words over %0d register writes and four idling profiles.",
                 sb.checked, reg_writes);
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
design/bfs_pkg.sv
design/bfs_graph_mem.sv
design/breadth_first_search.sv
tb/breadth_first_search_tb.sv
